// ----- src/gregorian_date_arithmetic_unit_assert.svh -----
// assertion macros used by the date unit checker
`ifndef GREGORIAN_DATE_ARITHMETIC_UNIT_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define GDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("date unit assertion failed");

// next-cycle implication
`define GDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("date unit assertion failed");

`endif

// ----- src/gda_pkg.sv -----
// types and constants of the gregorian date arithmetic unit
`timescale 1ns / 1ps

package gda_pkg;

	// day numbers reach about 113k (2099 date plus 65535 days)
	localparam int unsigned NUM_W = 17;

	localparam logic [11:0] FIRST_YEAR = 12'd1970;
	localparam logic [11:0] LAST_YEAR  = 12'd2099;
	localparam logic [11:0] END_YEAR   = 12'd2100;

	localparam logic [1:0] MODE_ADD  = 2'd0;
	localparam logic [1:0] MODE_SUB  = 2'd1;
	localparam logic [1:0] MODE_DIFF = 2'd2;
	localparam logic [1:0] MODE_RSVD = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [4:0]  day_a;
		logic [3:0]  month_a;
		logic [11:0] year_a;
		logic [4:0]  day_b;
		logic [3:0]  month_b;
		logic [11:0] year_b;
		logic [15:0] day_count;
	} gda_in_t;

	typedef struct packed {
		logic [4:0]  res_day;
		logic [3:0]  res_month;
		logic [11:0] res_year;
		logic [15:0] days_between;
		logic        error;
	} gda_out_t;

endpackage

// ----- src/gregorian_date_arithmetic_unit.sv -----
// gregorian date add, subtract and difference unit
// Usage:
//   in channel (in_valid/in_ready/in_data) takes one request: a mode, two dates and a
//   day count. out channel (out_valid/out_ready/out_data) returns one result per request.
//   Dates outside 1..31 / 1..12 / 1970..2099 are replaced by 1 Jan 1970.
// Sequence:
//   a request walks years and months one per cycle through a single shared
//   add/subtract unit: date to day number (years from 1970, then months, the day added
//   in the last month step), then back to a date the same way. A reserved mode or a
//   subtract that stays in the month skips the walk and goes straight to the result;
//   the sequencer goes idle as the result is loaded into the output register.
//   in_ready is high only while the sequencer is idle, so one request is at work
//   at a time; the next may start while the previous result waits in the output
//   register.
// Reset: arst_n clears the sequencer and the output valid; the unit comes up idle.
// Stall: a held result stays on out_data; the sequencer finishes its request
//   and waits until the output register is free before going idle.
`timescale 1ns / 1ps

module gregorian_date_arithmetic_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gda_pkg::gda_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output gda_pkg::gda_out_t out_data
);
	import gda_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TN_Y = 3'd1;
	localparam logic [2:0] ST_TN_M = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_FN_Y = 3'd4;
	localparam logic [2:0] ST_FN_M = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	// 4/100/400 rule reduced to the years 1970..2100
	function automatic logic leap_year(input logic [11:0] y);
		return (y[1:0] == 2'b00) && (y != END_YEAR);
	endfunction

	function automatic logic [8:0] year_len(input logic [11:0] y);
		return leap_year(y) ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
		logic [4:0] len;
		case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd2:                                     len = lp ? 5'd29 : 5'd28;
			default:                                  len = 5'd30;
		endcase
		return len;
	endfunction

	function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m,
		input logic [11:0] y);
		return (d != 5'd0) && (m != 4'd0) && (m <= 4'd12) &&
			(y >= FIRST_YEAR) && (y <= LAST_YEAR);
	endfunction

	logic [2:0]       state_q;
	logic             sel_b_q;
	logic             out_valid_q;
	gda_out_t         out_q;

	logic [1:0]       mode_q;
	logic [4:0]       da_q, db_q;
	logic [3:0]       ma_q, mb_q;
	logic [11:0]      ya_q, yb_q;
	logic [15:0]      cnt_q;
	logic [NUM_W-1:0] acc_q, na_q;
	logic [11:0]      yr_q;
	logic [3:0]       mon_q;
	gda_out_t         rslt_q;

	// validated request fields
	logic             ok_a, ok_b;
	logic [4:0]       va_day, vb_day;
	logic [3:0]       va_mon, vb_mon;
	logic [11:0]      va_yr, vb_yr;
	logic             in_acc, sub_short, out_free;

	assign ok_a   = date_ok(in_data.day_a, in_data.month_a, in_data.year_a);
	assign ok_b   = date_ok(in_data.day_b, in_data.month_b, in_data.year_b);
	assign va_day = ok_a ? in_data.day_a   : 5'd1;
	assign va_mon = ok_a ? in_data.month_a : 4'd1;
	assign va_yr  = ok_a ? in_data.year_a  : FIRST_YEAR;
	assign vb_day = ok_b ? in_data.day_b   : 5'd1;
	assign vb_mon = ok_b ? in_data.month_b : 4'd1;
	assign vb_yr  = ok_b ? in_data.year_b  : FIRST_YEAR;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	// subtract that stays inside the month keeps month and year as given
	assign sub_short = (in_data.mode == MODE_SUB) && (in_data.day_count < {11'd0, va_day});
	assign out_free  = !out_valid_q || out_ready;

	// date being converted to a day number
	logic [4:0]  tgt_d;
	logic [3:0]  tgt_m;
	logic [11:0] tgt_y;
	assign tgt_d = sel_b_q ? db_q : da_q;
	assign tgt_m = sel_b_q ? mb_q : ma_q;
	assign tgt_y = sel_b_q ? yb_q : ya_q;

	logic [8:0] yd;
	logic [4:0] md;
	assign yd = year_len(yr_q);
	assign md = month_len(mon_q, leap_year(yr_q));

	// shared add/subtract unit
	logic [NUM_W-1:0] alu_a, alu_b;
	logic             alu_sub;
	logic [NUM_W:0]   alu_y;
	logic             borrow;

	always_comb begin
		alu_a   = acc_q;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_TN_Y: alu_b = NUM_W'(yd);
			ST_TN_M: alu_b = (mon_q == tgt_m) ? NUM_W'(tgt_d - 5'd1) : NUM_W'(md);
			ST_FIN: begin
				case (mode_q)
					MODE_ADD: alu_b = NUM_W'(cnt_q);
					MODE_SUB: begin
						alu_b   = NUM_W'(cnt_q);
						alu_sub = 1'b1;
					end
					default: begin
						// first date minus second date
						alu_a   = na_q;
						alu_b   = acc_q;
						alu_sub = 1'b1;
					end
				endcase
			end
			ST_FN_Y: begin
				alu_b   = NUM_W'(yd);
				alu_sub = 1'b1;
			end
			ST_FN_M: begin
				alu_b   = NUM_W'(md);
				alu_sub = 1'b1;
			end
			default: ;
		endcase
		alu_y = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
	end

	assign borrow = alu_y[NUM_W];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_b_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						sel_b_q <= 1'b0;
						if (in_data.mode == MODE_RSVD || sub_short)
							state_q <= ST_DONE;
						else
							state_q <= ST_TN_Y;
					end
				end
				ST_TN_Y: begin
					if (yr_q == tgt_y)
						state_q <= ST_TN_M;
				end
				ST_TN_M: begin
					if (mon_q == tgt_m)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					case (mode_q)
						MODE_ADD: state_q <= ST_FN_Y;
						MODE_SUB: state_q <= borrow ? ST_DONE : ST_FN_Y;
						default: begin
							if (!sel_b_q) begin
								sel_b_q <= 1'b1;
								state_q <= ST_TN_Y;
							end else begin
								state_q <= ST_DONE;
							end
						end
					endcase
				end
				ST_FN_Y: begin
					if (yr_q == END_YEAR)
						state_q <= ST_DONE;
					else if (borrow)
						state_q <= ST_FN_M;
				end
				ST_FN_M: begin
					if (borrow)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					mode_q <= in_data.mode;
					da_q   <= va_day;
					ma_q   <= va_mon;
					ya_q   <= va_yr;
					db_q   <= vb_day;
					mb_q   <= vb_mon;
					yb_q   <= vb_yr;
					cnt_q  <= in_data.day_count;
					acc_q  <= '0;
					yr_q   <= FIRST_YEAR;
					mon_q  <= 4'd1;
					if (in_data.mode == MODE_RSVD)
						rslt_q <= {5'd0, 4'd0, 12'd0, 16'd0, 1'b1};
					else if (sub_short)
						rslt_q <= {va_day - in_data.day_count[4:0], va_mon, va_yr,
							16'd0, 1'b0};
					else
						rslt_q <= '0;
				end
			end
			ST_TN_Y: begin
				if (yr_q != tgt_y) begin
					acc_q <= alu_y[NUM_W-1:0];
					yr_q  <= yr_q + 12'd1;
				end
			end
			ST_TN_M: begin
				acc_q <= alu_y[NUM_W-1:0];
				if (mon_q != tgt_m)
					mon_q <= mon_q + 4'd1;
			end
			ST_FIN: begin
				yr_q  <= FIRST_YEAR;
				mon_q <= 4'd1;
				case (mode_q)
					MODE_ADD: acc_q <= alu_y[NUM_W-1:0];
					MODE_SUB: begin
						if (borrow)
							rslt_q.error <= 1'b1;
						else
							acc_q <= alu_y[NUM_W-1:0];
					end
					default: begin
						if (!sel_b_q) begin
							na_q  <= acc_q;
							acc_q <= '0;
						end else if (borrow) begin
							rslt_q.error <= 1'b1;
						end else begin
							rslt_q.days_between <= alu_y[15:0];
						end
					end
				endcase
			end
			ST_FN_Y: begin
				if (yr_q == END_YEAR)
					rslt_q.error <= 1'b1;
				else if (!borrow) begin
					acc_q <= alu_y[NUM_W-1:0];
					yr_q  <= yr_q + 12'd1;
				end
			end
			ST_FN_M: begin
				if (!borrow) begin
					acc_q <= alu_y[NUM_W-1:0];
					mon_q <= mon_q + 4'd1;
				end else begin
					// remainder is below the month length
					rslt_q.res_day   <= acc_q[4:0] + 5'd1;
					rslt_q.res_month <= mon_q;
					rslt_q.res_year  <= yr_q;
				end
			end
			ST_DONE: begin
				if (out_free)
					out_q <= rslt_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- src/gda_checker.sv -----
// port-level checker for the gregorian date arithmetic unit, bound to the top level
`timescale 1ns / 1ps
`include "gregorian_date_arithmetic_unit_assert.svh"

module gda_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input gda_pkg::gda_out_t out_data
);
	import gda_pkg::*;

	logic res_zero, date_legal;

	assign res_zero = (out_data.res_day == 5'd0) && (out_data.res_month == 4'd0) &&
		(out_data.res_year == 12'd0) && (out_data.days_between == 16'd0);
	assign date_legal = (out_data.days_between == 16'd0) && (out_data.res_day != 5'd0) &&
		(out_data.res_month <= 4'd12) && (out_data.res_year >= FIRST_YEAR) &&
		(out_data.res_year <= LAST_YEAR);

	// one request at a time: busy right after a request is taken
	`GDA_ASSERT_NEXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready)

	// an error result carries no date and no count
	`GDA_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid && out_data.error, res_zero)

	// a good date result has day, month and year in range and has no count
	`GDA_ASSERT_IMP(a_date_legal, clk, arst_n, out_valid && !out_data.error && out_data.res_month != 4'd0, date_legal)

	// stalled result holds
	`GDA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind gregorian_date_arithmetic_unit gda_checker u_gda_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// ----- dv/tb_gregorian_date_arithmetic_unit.sv -----
// self-checking testbench for the gregorian date arithmetic unit
`timescale 1ns / 1ps

module tb_gregorian_date_arithmetic_unit;
	import gda_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int unsigned DRAIN_CYCLES = 400;
	localparam int unsigned RANDOM_PER_PHASE = 116;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
	} cal_date_t;

	typedef struct {
		gda_in_t  req;
		bit       typed;
		gda_out_t want;
	} plan_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	gda_in_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	gda_out_t out_data;

	gda_out_t    pending_results[$];
	plan_row_t   directed_plan[$];
	int unsigned failures = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 24;
	int unsigned recv_idle_pct = 78;
	int unsigned hold_asks = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	gregorian_date_arithmetic_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic bit leap_year(int unsigned y);
		return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
	endfunction

	function automatic int unsigned month_length(int unsigned m, int unsigned y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			2: return leap_year(y) ? 29 : 28;
			default: return 30;
		endcase
	endfunction

	function automatic int unsigned year_length(int unsigned y);
		return leap_year(y) ? 366 : 365;
	endfunction

	// any field out of range sends the whole date to 1 Jan 1970
	function automatic cal_date_t clean_date(logic [4:0] d, logic [3:0] m, logic [11:0] y);
		cal_date_t dt;
		if (d < 1 || m < 1 || m > 12 || y < FIRST_YEAR || y > LAST_YEAR) begin
			dt.day = 5'd1;
			dt.month = 4'd1;
			dt.year = FIRST_YEAR;
		end else begin
			dt.day = d;
			dt.month = m;
			dt.year = y;
		end
		return dt;
	endfunction

	function automatic int unsigned serial_of(cal_date_t dt);
		int unsigned n;
		n = 0;
		for (int unsigned y = FIRST_YEAR; y < dt.year; y++)
			n += year_length(y);
		for (int unsigned m = 1; m < dt.month; m++)
			n += month_length(m, dt.year);
		return n + dt.day - 1;
	endfunction

	// false once the day number runs past the last year
	function automatic bit date_of_serial(int unsigned n, output cal_date_t dt);
		int unsigned left;
		int unsigned y;
		int unsigned m;
		dt = '0;
		left = n;
		y = FIRST_YEAR;
		while (y <= LAST_YEAR && left >= year_length(y)) begin
			left -= year_length(y);
			y++;
		end
		if (y > LAST_YEAR)
			return 1'b0;
		m = 1;
		while (left >= month_length(m, y)) begin
			left -= month_length(m, y);
			m++;
		end
		dt.day = 5'(left + 1);
		dt.month = 4'(m);
		dt.year = 12'(y);
		return 1'b1;
	endfunction

	function automatic gda_out_t predict_result(gda_in_t req);
		gda_out_t res;
		cal_date_t a;
		cal_date_t b;
		cal_date_t r;
		int unsigned na;
		int unsigned nb;
		res = '0;
		a = clean_date(req.day_a, req.month_a, req.year_a);
		b = clean_date(req.day_b, req.month_b, req.year_b);
		case (req.mode)
			MODE_ADD: begin
				if (date_of_serial(serial_of(a) + req.day_count, r))
					{res.res_day, res.res_month, res.res_year} = r;
				else
					res.error = 1'b1;
			end
			MODE_SUB: begin
				if (req.day_count < a.day) begin
					// stays in the month, date kept as given
					res.res_day = a.day - req.day_count[4:0];
					res.res_month = a.month;
					res.res_year = a.year;
				end else begin
					na = serial_of(a);
					if (req.day_count > na)
						res.error = 1'b1;
					else if (date_of_serial(na - req.day_count, r))
						{res.res_day, res.res_month, res.res_year} = r;
					else
						res.error = 1'b1;
				end
			end
			MODE_DIFF: begin
				na = serial_of(a);
				nb = serial_of(b);
				if (nb > na)
					res.error = 1'b1;
				else
					res.days_between = 16'(na - nb);
			end
			default: begin
				res.error = 1'b1;
			end
		endcase
		return res;
	endfunction

	function automatic gda_in_t make_req(logic [1:0] mode, int unsigned da, int unsigned ma,
			int unsigned ya, int unsigned db, int unsigned mb, int unsigned yb,
			int unsigned cnt);
		gda_in_t req;
		req.mode = mode;
		req.day_a = 5'(da);
		req.month_a = 4'(ma);
		req.year_a = 12'(ya);
		req.day_b = 5'(db);
		req.month_b = 4'(mb);
		req.year_b = 12'(yb);
		req.day_count = 16'(cnt);
		return req;
	endfunction

	function automatic gda_out_t make_res(int unsigned d, int unsigned m, int unsigned y,
			int unsigned between, bit err);
		gda_out_t res;
		res.res_day = 5'(d);
		res.res_month = 4'(m);
		res.res_year = 12'(y);
		res.days_between = 16'(between);
		res.error = err;
		return res;
	endfunction

	function automatic gda_in_t random_request();
		gda_in_t req;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		req = raw[59:0];
		// most requests carry valid dates so the walk runs deep, the rest is noise
		if ($urandom_range(99) >= 15) begin
			req.mode = 2'($urandom_range(2));
			req.day_a = 5'($urandom_range(31, 1));
			req.month_a = 4'($urandom_range(12, 1));
			req.year_a = 12'($urandom_range(LAST_YEAR, FIRST_YEAR));
			req.day_b = 5'($urandom_range(31, 1));
			req.month_b = 4'($urandom_range(12, 1));
			req.year_b = ($urandom_range(2) == 0) ? req.year_a :
				12'($urandom_range(LAST_YEAR, FIRST_YEAR));
			case ($urandom_range(3))
				0: req.day_count = 16'($urandom_range(31));
				1: req.day_count = 16'($urandom_range(400));
				2: req.day_count = 16'($urandom_range(20000));
				default: req.day_count = raw[15:0];
			endcase
		end
		return req;
	endfunction

	task automatic check_result(gda_out_t got);
		gda_out_t want;
		if (pending_results.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected result %h at cycle %0d", got, cycle_count);
			return;
		end
		want = pending_results.pop_front();
		if (got.res_day !== want.res_day || got.res_month !== want.res_month ||
				got.res_year !== want.res_year || got.days_between !== want.days_between ||
				got.error !== want.error) begin
			failures++;
			if (failures <= 10)
				$display("mismatch exp %0d/%0d/%0d days %0d err %0b got %0d/%0d/%0d days %0d err %0b",
					want.res_day, want.res_month, want.res_year, want.days_between, want.error,
					got.res_day, got.res_month, got.res_year, got.days_between, got.error);
		end
	endtask

	// result side: check, then pick the next ready, with a long hold-off on request
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_result(out_data);
		if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// returns at the edge that accepts the request
	task automatic send_request(gda_in_t req, gda_out_t want);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(want);
	endtask

	initial begin : stimulus
		gda_in_t req;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_plan.push_back('{make_req(MODE_ADD, 1, 1, 1970, 1, 1, 1970, 0), 1'b1,
			make_res(1, 1, 1970, 0, 1'b0)});
		directed_plan.push_back('{make_req(MODE_RSVD, 31, 15, 4095, 31, 15, 4095, 16'hFFFF),
			1'b1, make_res(0, 0, 0, 0, 1'b1)});
		directed_plan.push_back('{make_req(MODE_SUB, 1, 1, 1970, 0, 0, 0, 1), 1'b1,
			make_res(0, 0, 0, 0, 1'b1)});
		// day zero makes the date invalid
		directed_plan.push_back('{make_req(MODE_SUB, 0, 1, 2000, 0, 0, 0, 0), 1'b1,
			make_res(1, 1, 1970, 0, 1'b0)});
		directed_plan.push_back('{make_req(MODE_ADD, 31, 12, 2099, 31, 15, 4095, 0), 1'b1,
			make_res(31, 12, 2099, 0, 1'b0)});
		directed_plan.push_back('{make_req(MODE_ADD, 31, 12, 2099, 0, 0, 0, 1), 1'b1,
			make_res(0, 0, 0, 0, 1'b1)});
		directed_plan.push_back('{make_req(MODE_ADD, 1, 1, 1970, 0, 0, 0, 16'hFFFF), 1'b1,
			make_res(0, 0, 0, 0, 1'b1)});
		directed_plan.push_back('{make_req(MODE_SUB, 31, 12, 2099, 0, 0, 0, 16'hFFFF), 1'b1,
			make_res(0, 0, 0, 0, 1'b1)});
		directed_plan.push_back('{make_req(MODE_SUB, 20, 5, 2000, 0, 0, 0, 5), 1'b1,
			make_res(15, 5, 2000, 0, 1'b0)});
		directed_plan.push_back('{make_req(MODE_SUB, 1, 3, 2000, 0, 0, 0, 1), 1'b1,
			make_res(29, 2, 2000, 0, 1'b0)});
		directed_plan.push_back('{make_req(MODE_SUB, 1, 3, 2001, 0, 0, 0, 1), 1'b1,
			make_res(28, 2, 2001, 0, 1'b0)});
		directed_plan.push_back('{make_req(MODE_ADD, 28, 2, 2000, 0, 0, 0, 1), 1'b1,
			make_res(29, 2, 2000, 0, 1'b0)});
		// year past the range falls back to the epoch
		directed_plan.push_back('{make_req(MODE_ADD, 28, 2, END_YEAR, 0, 0, 0, 1), 1'b1,
			make_res(2, 1, 1970, 0, 1'b0)});
		// day 31 runs on into the next month
		directed_plan.push_back('{make_req(MODE_ADD, 31, 2, 2001, 0, 0, 0, 0), 1'b1,
			make_res(3, 3, 2001, 0, 1'b0)});
		directed_plan.push_back('{make_req(MODE_DIFF, 31, 12, 2099, 1, 1, 1970, 16'hFFFF), 1'b1,
			make_res(0, 0, 0, 47481, 1'b0)});
		directed_plan.push_back('{make_req(MODE_DIFF, 1, 1, 1970, 2, 1, 1970, 0), 1'b1,
			make_res(0, 0, 0, 0, 1'b1)});
		directed_plan.push_back('{make_req(MODE_DIFF, 15, 6, 2050, 15, 6, 2050, 7), 1'b1,
			make_res(0, 0, 0, 0, 1'b0)});
		directed_plan.push_back('{make_req(MODE_DIFF, 10, 13, 2000, 10, 5, 1969, 0), 1'b1,
			make_res(0, 0, 0, 0, 1'b0)});
		directed_plan.push_back('{make_req(MODE_ADD, 15, 0, 2099, 0, 0, 0, 100), 1'b0, '0});
		directed_plan.push_back('{make_req(MODE_SUB, 31, 12, 2099, 0, 0, 0, 47481), 1'b1,
			make_res(1, 1, 1970, 0, 1'b0)});
		directed_plan.push_back('{make_req(MODE_SUB, 31, 12, 2099, 0, 0, 0, 47482), 1'b1,
			make_res(0, 0, 0, 0, 1'b1)});
		directed_plan.push_back('{make_req(MODE_ADD, 1, 1, 1970, 0, 0, 0, 47481), 1'b1,
			make_res(31, 12, 2099, 0, 1'b0)});
		directed_plan.push_back('{make_req(MODE_ADD, 1, 1, 1970, 0, 0, 0, 47482), 1'b1,
			make_res(0, 0, 0, 0, 1'b1)});
		// count equal to the day borrows from the month before
		directed_plan.push_back('{make_req(MODE_SUB, 31, 1, 2024, 0, 0, 0, 31), 1'b1,
			make_res(31, 12, 2023, 0, 1'b0)});
		directed_plan.push_back('{make_req(MODE_DIFF, 1, 3, 2024, 28, 2, 2023, 0), 1'b0, '0});

		foreach (directed_plan[i])
			send_request(directed_plan[i].req,
				directed_plan[i].typed ? directed_plan[i].want : predict_result(directed_plan[i].req));

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 78;
				end
				1: begin
					send_idle_pct = 78;
					recv_idle_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				// receiver blocks for a while, requests keep coming until the unit backs up
				if (phase == 0 && i == 40)
					hold_asks++;
				// let the unit drain completely before going on
				if (phase == 1 && i == 60) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (pending_results.size() != 0);
				end
				req = random_request();
				send_request(req, predict_result(req));
			end
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
